[design/fbdpe_pkg.sv]
// Package for the four-button debounce and press encoder: types, constants, action lookup.
`default_nettype none
package fbdpe_pkg;

  localparam int unsigned NumButtons   = 4;
  localparam int unsigned IdxWidth     = (NumButtons > 1) ? $clog2(NumButtons) : 1;
  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned DebWidth     = 16;
  localparam int unsigned ActionWidth  = 4;
  localparam logic [DebWidth-1:0] DebounceReset = 16'd50;

  // Action codes returned per poll
  typedef enum logic [ActionWidth-1:0] {
    ActNone     = 4'd0,
    ActStart    = 4'd1,
    ActClock    = 4'd2,
    ActShowGps  = 4'd3,
    ActStop     = 4'd4,
    ActPlus     = 4'd5,
    ActNext     = 4'd6,
    ActBack     = 4'd7,
    ActMinus    = 4'd8
  } action_e;

  // Action set selector
  typedef enum logic {
    SetPrimary   = 1'b0,
    SetSecondary = 1'b1
  } action_set_e;

  // Commit controls from the merge stage to one lane
  typedef struct packed {
    logic commit;     // lane state takes this poll's update
    logic hold_last;  // lane ends the poll: keep its last raw level
  } lane_ctrl_t;

  // Map an action set and a button index to its action code
  function automatic action_e action_for(action_set_e set, logic [IdxWidth-1:0] idx);
    action_e act;
    act = ActNone;
    case (idx)
      2'd0: act = (set == SetSecondary) ? ActPlus  : ActStart;
      2'd1: act = (set == SetSecondary) ? ActNext  : ActClock;
      2'd2: act = (set == SetSecondary) ? ActBack  : ActShowGps;
      2'd3: act = (set == SetSecondary) ? ActMinus : ActStop;
      default: act = ActNone;
    endcase
    return act;
  endfunction

endpackage
`default_nettype wire

[design/fbdpe_lane.sv]
// One debounce lane: per-button state, hold-time check and press detect.
`default_nettype none
module fbdpe_lane (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                accept_i,
  input  wire logic                                raw_i,
  input  wire logic [fbdpe_pkg::TimeWidth-1:0]     now_ms_i,
  input  wire logic [fbdpe_pkg::DebWidth-1:0]      debounce_ms_i,
  input  wire fbdpe_pkg::lane_ctrl_t               ctrl_i,
  output logic                                     press_o
);

  logic                              last_raw_q, last_raw_d;
  logic                              stable_q, stable_d;
  logic [fbdpe_pkg::TimeWidth-1:0]   stamp_q, stamp_d;
  logic [fbdpe_pkg::TimeWidth-1:0]   held;
  logic                              settle;

  // Restamp on a raw change, then check the hold time against the delay
  always_comb begin
    stamp_d    = (raw_i != last_raw_q) ? now_ms_i : stamp_q;
    held       = now_ms_i - stamp_d;
    settle     = (held > {{(fbdpe_pkg::TimeWidth-fbdpe_pkg::DebWidth){1'b0}}, debounce_ms_i})
                 && (raw_i != stable_q);
    stable_d   = settle ? raw_i : stable_q;
    last_raw_d = ctrl_i.hold_last ? last_raw_q : raw_i;
    press_o    = settle && !raw_i;
  end

  // Commit lane state for an accepted item when the merge stage sets commit for this lane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b1;
      stable_q   <= 1'b1;
      stamp_q    <= '0;
    end else if (accept_i && ctrl_i.commit) begin
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      stamp_q    <= stamp_d;
    end
  end

endmodule
`default_nettype wire

[design/fbdpe_merge.sv]
// Merge stage: pick the first pressed lane, gate later lanes and encode the action.
`default_nettype none
module fbdpe_merge (
  input  wire logic [fbdpe_pkg::NumButtons-1:0]    press_i,
  input  wire logic                                opcode_i,
  output fbdpe_pkg::lane_ctrl_t [fbdpe_pkg::NumButtons-1:0] ctrl_o,
  output fbdpe_pkg::action_e                       action_o
);

  logic [fbdpe_pkg::NumButtons-1:0]  earlier;
  logic [fbdpe_pkg::IdxWidth-1:0]    first_idx;

  // Flag lanes that sit after a pressed lane
  always_comb begin
    earlier[0] = 1'b0;
    for (int i = 1; i < fbdpe_pkg::NumButtons; i++) begin
      earlier[i] = earlier[i-1] | press_i[i-1];
    end
  end

  // Drive lane controls and find the winning lane
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < fbdpe_pkg::NumButtons; i++) begin
      ctrl_o[i].commit    = !earlier[i];
      ctrl_o[i].hold_last = press_i[i];
      if (press_i[i] && !earlier[i]) begin
        first_idx = fbdpe_pkg::IdxWidth'(i);
      end
    end
  end

  // Encode the action for the first press
  always_comb begin
    if (|press_i) begin
      action_o = fbdpe_pkg::action_for(fbdpe_pkg::action_set_e'(opcode_i), first_idx);
    end else begin
      action_o = fbdpe_pkg::ActNone;
    end
  end

endmodule
`default_nettype wire

[design/four_button_debounce_press_encoder.sv]
// Top level: four debounce lanes, merge stage, output register and debounce register.
// The action of an accepted poll is captured in the output register when the poll is accepted.
// Throughput: one poll per cycle; the lane compares and state commit are done for each accepted poll.
// Input stalls only while a finished action waits unread.
// Reset: all buttons released, change stamps zero, debounce delay 50 ms, output empty.
`default_nettype none
module four_button_debounce_press_encoder (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_wr_en_i,
  input  wire logic [fbdpe_pkg::DebWidth-1:0]      cfg_wr_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [fbdpe_pkg::NumButtons-1:0]    button_levels_i,
  input  wire logic [fbdpe_pkg::TimeWidth-1:0]     now_ms_i,
  input  wire logic                                opcode_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [fbdpe_pkg::ActionWidth-1:0]        action_o
);

  logic [fbdpe_pkg::DebWidth-1:0]                  debounce_ms_q;
  logic                                            out_valid_q, out_valid_d;
  fbdpe_pkg::action_e                              action_q, action_d;
  logic                                            accept;
  logic [fbdpe_pkg::NumButtons-1:0]                press;
  fbdpe_pkg::lane_ctrl_t [fbdpe_pkg::NumButtons-1:0] ctrl;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign action_o    = action_q;

  // Hold the debounce delay register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q <= fbdpe_pkg::DebounceReset;
    end else if (cfg_wr_en_i) begin
      debounce_ms_q <= cfg_wr_data_i;
    end
  end

  // One lane per button
  for (genvar g = 0; g < fbdpe_pkg::NumButtons; g++) begin : g_lane
    fbdpe_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .accept_i      (accept),
      .raw_i         (button_levels_i[g]),
      .now_ms_i      (now_ms_i),
      .debounce_ms_i (debounce_ms_q),
      .ctrl_i        (ctrl[g]),
      .press_o       (press[g])
    );
  end

  fbdpe_merge u_merge (
    .press_i  (press),
    .opcode_i (opcode_i),
    .ctrl_o   (ctrl),
    .action_o (action_d)
  );

  // Advance the output register when an item is accepted, drop it when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_d;
    end
  end

endmodule
`default_nettype wire

[tb/four_button_debounce_press_encoder_tb.sv]
// Testbench for the four-button debounce and press encoder: directed and random polls.
`timescale 1ns / 1ps

// Track button state per poll and hold the actions still owed by the block
class press_scoreboard;
  logic [fbdpe_pkg::DebWidth-1:0]   debounce;
  logic [fbdpe_pkg::NumButtons-1:0] last_raw;
  logic [fbdpe_pkg::NumButtons-1:0] stable;
  logic [fbdpe_pkg::TimeWidth-1:0]  stamp [fbdpe_pkg::NumButtons];
  fbdpe_pkg::action_e               expected_q [$];
  int                               errors;

  function new();
    int i;
    debounce = fbdpe_pkg::DebounceReset;
    last_raw = '1;
    stable   = '1;
    for (i = 0; i < fbdpe_pkg::NumButtons; i++) stamp[i] = '0;
    errors = 0;
  endfunction

  function void set_debounce(logic [fbdpe_pkg::DebWidth-1:0] value);
    debounce = value;
  endfunction

  // Walk the buttons in order; a new press ends the walk
  function void note_poll(logic [fbdpe_pkg::NumButtons-1:0] levels,
                          logic [fbdpe_pkg::TimeWidth-1:0] now,
                          fbdpe_pkg::action_set_e set);
    int i;
    logic raw;
    logic done;
    logic [fbdpe_pkg::TimeWidth-1:0] held;
    fbdpe_pkg::action_e act;
    act  = fbdpe_pkg::ActNone;
    done = 1'b0;
    for (i = 0; i < fbdpe_pkg::NumButtons; i++) begin
      if (!done) begin
        raw = levels[i];
        if (raw != last_raw[i]) stamp[i] = now;
        held = now - stamp[i];
        if (held > {{(fbdpe_pkg::TimeWidth-fbdpe_pkg::DebWidth){1'b0}}, debounce}
            && raw != stable[i]) begin
          stable[i] = raw;
          if (!raw) begin
            act  = fbdpe_pkg::action_e'(fbdpe_pkg::ActStart + i +
                   ((set == fbdpe_pkg::SetSecondary) ? fbdpe_pkg::NumButtons : 0));
            done = 1'b1;
          end
        end
        // Keep the last raw level of the button that ends the poll
        if (!done) last_raw[i] = raw;
      end
    end
    expected_q.push_back(act);
  endfunction

  function void check_action(logic [fbdpe_pkg::ActionWidth-1:0] got);
    fbdpe_pkg::action_e want;
    if (expected_q.size() == 0) begin
      $display("%0t: action %0d arrived with no poll waiting", $time, got);
      errors++;
    end else begin
      want = expected_q.pop_front();
      if (got !== want) begin
        $display("%0t: action mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    end
  endfunction
endclass

module four_button_debounce_press_encoder_tb;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_wr_en_i;
  logic [fbdpe_pkg::DebWidth-1:0]      cfg_wr_data_i;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic [fbdpe_pkg::NumButtons-1:0]    button_levels_i;
  logic [fbdpe_pkg::TimeWidth-1:0]     now_ms_i;
  logic                                opcode_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic [fbdpe_pkg::ActionWidth-1:0]   action_o;

  press_scoreboard                     sb;
  logic                                idle_on;
  logic                                hold_req;
  logic [fbdpe_pkg::TimeWidth-1:0]     clock_ms;
  logic [fbdpe_pkg::NumButtons-1:0]    phys;

  four_button_debounce_press_encoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_levels_i(button_levels_i),
    .now_ms_i       (now_ms_i),
    .opcode_i       (opcode_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // End a hung run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Check each action as it leaves the block
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_action(action_o);
  end

  // Stall the result side in bursts, and once for a long stretch on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one poll, wait for it to be taken, return at the next falling edge
  task automatic send_poll(input logic [fbdpe_pkg::NumButtons-1:0] levels,
                           input logic [fbdpe_pkg::TimeWidth-1:0] now,
                           input fbdpe_pkg::action_set_e set);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    button_levels_i <= levels;
    now_ms_i        <= now;
    opcode_i        <= set;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_poll(levels, now, set);
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every owed action
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_debounce(input logic [fbdpe_pkg::DebWidth-1:0] value);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    sb.set_debounce(value);
  endtask

  // Mostly steady holds with occasional presses; the rest bounces, jumps and noise
  task automatic run_random(input int count, input int step_max);
    int k;
    int r;
    int b;
    logic [fbdpe_pkg::NumButtons-1:0] levels;
    fbdpe_pkg::action_set_e set;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        clock_ms = clock_ms + $urandom_range(0, step_max);
        if ($urandom_range(0, 9) == 0) begin
          b = $urandom_range(0, fbdpe_pkg::NumButtons - 1);
          phys[b] = ~phys[b];
        end
        levels = phys;
      end else if (r < 86) begin
        clock_ms = clock_ms + $urandom_range(0, 2);
        levels = phys ^ fbdpe_pkg::NumButtons'($urandom_range(1, 15));
      end else if (r < 93) begin
        clock_ms = $urandom();
        levels = fbdpe_pkg::NumButtons'($urandom_range(0, 15));
      end else begin
        clock_ms = clock_ms - $urandom_range(1, step_max + 1);
        levels = phys;
      end
      set = fbdpe_pkg::action_set_e'($urandom_range(0, 1));
      send_poll(levels, clock_ms, set);
    end
  endtask

  initial begin
    logic [fbdpe_pkg::DebWidth-1:0] deb;
    int ph;
    sb              = new();
    rst_ni          = 1'b0;
    cfg_wr_en_i     = 1'b0;
    cfg_wr_data_i   = '0;
    in_valid_i      = 1'b0;
    button_levels_i = '1;
    now_ms_i        = '0;
    opcode_i        = 1'b0;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    phys            = '1;
    clock_ms        = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Hold at exactly the delay, then one past it
    send_poll(4'hF, 32'd0,   fbdpe_pkg::SetPrimary);
    send_poll(4'hE, 32'd10,  fbdpe_pkg::SetPrimary);
    send_poll(4'hE, 32'd60,  fbdpe_pkg::SetPrimary);
    send_poll(4'hE, 32'd61,  fbdpe_pkg::SetPrimary);
    // Several buttons due in one poll: one press per poll, in button order
    send_poll(4'h0, 32'd100, fbdpe_pkg::SetSecondary);
    send_poll(4'h0, 32'd151, fbdpe_pkg::SetSecondary);
    send_poll(4'h0, 32'd151, fbdpe_pkg::SetSecondary);
    send_poll(4'h0, 32'd151, fbdpe_pkg::SetPrimary);
    // Debounced releases return nothing and do not end the poll
    send_poll(4'hF, 32'd200, fbdpe_pkg::SetPrimary);
    send_poll(4'hF, 32'd251, fbdpe_pkg::SetPrimary);
    // A later button bounces in the poll that ends early: its last level stays
    send_poll(4'hB, 32'd300, fbdpe_pkg::SetPrimary);
    send_poll(4'hA, 32'd340, fbdpe_pkg::SetPrimary);
    send_poll(4'hE, 32'd400, fbdpe_pkg::SetPrimary);
    send_poll(4'hA, 32'd401, fbdpe_pkg::SetPrimary);
    // Hold across the time wrap
    send_poll(4'hF, 32'hFFFF_FFE0, fbdpe_pkg::SetSecondary);
    send_poll(4'h7, 32'hFFFF_FFF0, fbdpe_pkg::SetSecondary);
    send_poll(4'h7, 32'h0000_0021, fbdpe_pkg::SetSecondary);
    send_poll(4'h7, 32'h0000_0023, fbdpe_pkg::SetSecondary);
    // Time stepping backwards reads as a very long hold
    send_poll(4'h5, 32'h0000_0100, fbdpe_pkg::SetPrimary);
    send_poll(4'h5, 32'h0000_00FF, fbdpe_pkg::SetPrimary);
    send_poll(4'hF, 32'hFFFF_FFFF, fbdpe_pkg::SetSecondary);
    send_poll(4'h0, 32'hFFFF_FFFF, fbdpe_pkg::SetSecondary);
    drain();

    // Sweep the delay through its extremes and a random value
    clock_ms = 32'hFFFF_0000;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       deb = 16'd0;
        1:       deb = 16'hFFFF;
        2:       deb = fbdpe_pkg::DebounceReset;
        3:       deb = fbdpe_pkg::DebWidth'($urandom_range(2, 65534));
        default: deb = 16'd1;
      endcase
      if (ph == 4) idle_on = 1'b0;
      write_debounce(deb);
      if (ph == 3) begin
        run_random(60, deb / 4 + 3);
        hold_req = 1'b1;
        run_random(75, deb / 4 + 3);
      end else begin
        run_random(135, deb / 4 + 3);
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (sb.expected_q.size() != 0)
        $display("%0t: %0d actions never arrived", $time, sb.expected_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
design/fbdpe_pkg.sv
design/fbdpe_lane.sv
design/fbdpe_merge.sv
design/four_button_debounce_press_encoder.sv
tb/four_button_debounce_press_encoder_tb.sv
